FILE: rtl/cbba_pkg.sv
`default_nettype none

package cbba_pkg;

   localparam int MAX_BLOCKS = 16384;
   localparam int MAX_RUN    = 256;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;

   localparam int PTR_W  = $clog2(MAX_BLOCKS) + 1;   // holds the limit itself
   localparam int BLK_W  = $clog2(MAX_BLOCKS);
   localparam int WIDX_W = $clog2(MAP_WORDS);
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int RUN_W  = 9;
   localparam int STAT_W = 2;
   localparam int KIND_W = 2;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [KIND_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_MARK  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 2'd0,
      ST_EXHAUSTED    = 2'd1,
      ST_OUT_OF_RANGE = 2'd2
   } rsp_status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SKIP_FETCH,
      S_SKIP,
      S_CHECK_FETCH,
      S_CHECK,
      S_FOUND,
      S_MARK_CHECK,
      S_MARK_FETCH,
      S_MARK_WRITE,
      S_READ_FETCH,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic rd_pos;
      logic skip_take;
      logic to_block;
      logic next_word;
      logic found;
      logic fail;
      logic range_err;
      logic mark_write;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pos_at_limit;
      logic skip_hit;
      logic skip_cross;
      logic need_one;
      logic chk_fit;
      logic chk_blocked;
      logic run_zero;
      logic mark_last;
      logic rsp_free;
   } dp_stat_type;

   // Lowest set bit of a word: {any, index}.
   function automatic logic [BIT_W:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, BIT_W'(i)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/contiguous_block_bitmap_allocator.sv
// Next-fit allocator of contiguous block runs over a 16384-block used/free
// bitmap held in a 512 x 32 memory. After reset the block clears the
// bitmap, one word a cycle, and takes no request until done; the
// tracked-count register may be written at any idle time. An allocate
// request walks the bitmap from the search pointer one word at a time:
// each word is fetched and then scanned, with a further scan step for every
// used/free boundary met inside it, and a run found is then marked with a
// read-modify-write of every word it touches. The result sits in an output
// register, so the next request is taken while it waits.
`default_nettype none

module contiguous_block_bitmap_allocator
   import cbba_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // run_length[8:0], block_number[22:9], word_index[31:23]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // run_start[13:0], bitmap_word[45:14], zero fill[47:46]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [STAT_W-1:0]          rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [PTR_W-1:0]      csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   cbba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   cbba_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

FILE: rtl/cbba_ctrl.sv
`default_nettype none

module cbba_ctrl
   import cbba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               unique case (req_kind_type'(req_kind))
                  REQ_ALLOC: state_in = S_SKIP_FETCH;
                  REQ_MARK:  state_in = S_MARK_CHECK;
                  REQ_READ:  state_in = S_READ_FETCH;
                  REQ_NONE:  state_in = S_DONE;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_SKIP_FETCH: begin
            if (stat.pos_at_limit) begin
               cmd.fail = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_pos = 1'b1;
               state_in   = S_SKIP;
            end
         end
         S_SKIP: begin
            if (stat.skip_hit) begin
               cmd.skip_take = 1'b1;
               priority if (stat.need_one) begin
                  state_in = S_FOUND;
               end else if (stat.skip_cross) begin
                  state_in = S_CHECK_FETCH;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               cmd.next_word = 1'b1;
               state_in      = S_SKIP_FETCH;
            end
         end
         S_CHECK_FETCH: begin
            if (stat.pos_at_limit) begin
               cmd.fail = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_pos = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (stat.chk_fit) begin
               state_in = S_FOUND;
            end else if (stat.chk_blocked) begin
               cmd.to_block = 1'b1;
               state_in     = S_SKIP;
            end else begin
               cmd.next_word = 1'b1;
               state_in      = S_CHECK_FETCH;
            end
         end
         S_FOUND: begin
            cmd.found = 1'b1;
            state_in  = stat.run_zero ? S_DONE : S_MARK_FETCH;
         end
         S_MARK_CHECK: begin
            if (stat.pos_at_limit) begin
               cmd.range_err = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_MARK_FETCH;
            end
         end
         S_MARK_FETCH: begin
            cmd.rd_pos = 1'b1;
            state_in   = S_MARK_WRITE;
         end
         S_MARK_WRITE: begin
            cmd.mark_write = 1'b1;
            state_in       = stat.mark_last ? S_DONE : S_MARK_FETCH;
         end
         S_READ_FETCH: begin
            cmd.rd_pos = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/cbba_dp.sv
`default_nettype none

module cbba_dp
   import cbba_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [STAT_W-1:0]          rsp_tuser,
   input  wire logic                  csr_valid,
   input  wire logic [PTR_W-1:0]      csr_data,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat
);

   localparam logic [PTR_W-1:0] LIMIT_MAX = PTR_W'(MAX_BLOCKS);
   localparam logic [RUN_W-1:0] RUN_MAX   = RUN_W'(MAX_RUN);
   localparam logic [PTR_W:0]   WORD_STEP = (PTR_W+1)'(WORD_BITS);

   // Used/free bitmap, one bit per block, set means used.
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_wr;
   logic [WIDX_W-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;

   logic [WIDX_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [PTR_W-1:0]     limit_ff, limit_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [PTR_W-1:0]     pos_ff, pos_in;
   logic [PTR_W-1:0]     start_ff, start_in;
   logic [PTR_W-1:0]     end_ff, end_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]    rsp_user_ff, rsp_user_in;

   logic [RUN_W-1:0]     in_run;
   logic [BLK_W-1:0]     in_blk;
   logic [WIDX_W-1:0]    in_widx;
   logic [RUN_W-1:0]     run_sat;

   logic [PTR_W-1:0]     base;
   logic [PTR_W:0]       word_end;
   logic [BIT_W-1:0]     bit_off;
   logic [WORD_BITS-1:0] valid_mask, from_mask, mark_mask;
   logic [WORD_BITS-1:0] free_avail, blocked;
   logic [BIT_W:0]       free_hit, block_hit;
   logic [PTR_W:0]       need_end, stop;
   logic [PTR_W-1:0]     run_end;
   logic [BLK_W-1:0]     rsp_first;
   logic [WORD_BITS-1:0] rsp_word;

   assign in_run  = req_tdata[RUN_W-1:0];
   assign in_blk  = req_tdata[RUN_W +: BLK_W];
   assign in_widx = req_tdata[RUN_W+BLK_W +: WIDX_W];
   assign run_sat = (in_run > RUN_MAX) ? RUN_MAX : in_run;

   // Word-level view of the current scan or mark position.
   assign base     = {pos_ff[PTR_W-1:BIT_W], BIT_W'(0)};
   assign word_end = {1'b0, base} + WORD_STEP;
   assign bit_off  = pos_ff[BIT_W-1:0];

   // The scan only looks at a word whose position is below the limit, so the
   // limit either lies beyond this word or inside it.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         valid_mask[i] = (limit_ff[PTR_W-1:BIT_W] != pos_ff[PTR_W-1:BIT_W]) ||
                         (BIT_W'(i) < limit_ff[BIT_W-1:0]);
         from_mask[i]  = BIT_W'(i) >= bit_off;
         mark_mask[i]  = from_mask[i] &&
                         ((end_ff[PTR_W-1:BIT_W] != pos_ff[PTR_W-1:BIT_W]) ||
                          (BIT_W'(i) < end_ff[BIT_W-1:0]));
      end
   end

   assign free_avail = ~rd_data_ff & valid_mask & from_mask;
   assign blocked    = (rd_data_ff | ~valid_mask) & from_mask;
   assign free_hit   = lowest_set(free_avail);
   assign block_hit  = lowest_set(blocked);

   assign need_end = {1'b0, start_ff} + (PTR_W+1)'((run_ff == '0) ? RUN_W'(1) : run_ff);
   assign stop     = block_hit[BIT_W] ? {1'b0, base | PTR_W'(block_hit[BIT_W-1:0])}
                                      : word_end;
   assign run_end  = start_ff + PTR_W'(run_ff);

   assign stat.clear_last   = (clr_cnt_ff == WIDX_W'(MAP_WORDS - 1));
   assign stat.pos_at_limit = pos_ff >= limit_ff;
   assign stat.skip_hit     = free_hit[BIT_W];
   assign stat.skip_cross   = (free_hit[BIT_W-1:0] == BIT_W'(WORD_BITS - 1));
   assign stat.need_one     = run_ff <= RUN_W'(1);
   assign stat.chk_fit      = need_end <= stop;
   assign stat.chk_blocked  = block_hit[BIT_W];
   assign stat.run_zero     = run_ff == '0;
   assign stat.mark_last    = word_end >= {1'b0, end_ff};
   assign stat.rsp_free     = !rsp_valid_ff || rsp_tready;

   // Memory port control.
   always_comb begin
      mem_wr      = cmd.clear_wr || cmd.mark_write;
      mem_wr_addr = cmd.clear_wr ? clr_cnt_ff : pos_ff[BLK_W-1:BIT_W];
      mem_wr_data = cmd.clear_wr ? '0 : (rd_data_ff | mark_mask);
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         map_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (cmd.rd_pos) begin
         rd_data_ff <= map_mem[pos_ff[BLK_W-1:BIT_W]];
      end
   end

   always_comb begin
      clr_cnt_in = cmd.clear_wr ? clr_cnt_ff + WIDX_W'(1) : clr_cnt_ff;
      limit_in   = limit_ff;
      if (csr_valid) begin
         limit_in = (csr_data > LIMIT_MAX) ? LIMIT_MAX : csr_data;
      end

      ptr_in = ptr_ff;
      if (cmd.found) begin
         ptr_in = (run_ff == '0) ? start_ff : run_end;
      end else if (cmd.fail && (ptr_ff < limit_ff)) begin
         ptr_in = limit_ff;
      end

      pos_in    = pos_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      run_in    = run_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      priority if (cmd.load_req) begin
         kind_in   = req_tuser;
         run_in    = run_sat;
         status_in = ST_OK;
         unique case (req_kind_type'(req_tuser))
            REQ_ALLOC: pos_in = ptr_ff;
            REQ_MARK: begin
               pos_in = PTR_W'(in_blk);
               end_in = PTR_W'(in_blk) + PTR_W'(1);
            end
            REQ_READ:  pos_in = PTR_W'({in_widx, BIT_W'(0)});
            REQ_NONE:  pos_in = pos_ff;
            default:   pos_in = pos_ff;
         endcase
      end else if (cmd.skip_take) begin
         start_in = base | PTR_W'(free_hit[BIT_W-1:0]);
         pos_in   = (base | PTR_W'(free_hit[BIT_W-1:0])) + PTR_W'(1);
      end else if (cmd.to_block) begin
         pos_in = stop[PTR_W-1:0];
      end else if (cmd.next_word || cmd.mark_write) begin
         pos_in = word_end[PTR_W-1:0];
      end else if (cmd.found) begin
         pos_in = start_ff;
         end_in = run_end;
      end else if (cmd.fail) begin
         status_in = ST_EXHAUSTED;
      end else if (cmd.range_err) begin
         status_in = ST_OUT_OF_RANGE;
      end
   end

   // Result register; it frees the controller while the result waits.
   always_comb begin
      rsp_first = ((kind_ff == REQ_ALLOC) && (status_ff == ST_OK)) ?
                  start_ff[BLK_W-1:0] : '0;
      rsp_word  = (kind_ff == REQ_READ) ? rd_data_ff : '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RSP_DATA_W - BLK_W - WORD_BITS)'(0), rsp_word, rsp_first};
         rsp_user_in  = status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         limit_ff     <= LIMIT_MAX;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         limit_ff     <= limit_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      run_ff      <= run_in;
      kind_ff     <= kind_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: sim/contiguous_block_bitmap_allocator_test.sv
`default_nettype none

module contiguous_block_bitmap_allocator_test
   import cbba_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [BLK_W-1:0]     run_start;
      rsp_status_type       status;
      logic [WORD_BITS-1:0] bitmap_word;
   } allocator_answer_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [PTR_W-1:0]      csr_data   = '0;

   // Shadow copy of the allocator state.
   bit          used_blk [MAX_BLOCKS];
   int unsigned seek_ptr    = 0;
   int unsigned tracked_cfg = MAX_BLOCKS;

   allocator_answer_type answer_queue[$];
   int  errors  = 0;
   int  cycles  = 0;
   bit  no_idle = 1'b0;

   always #2 clock = ~clock;

   contiguous_block_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at cycle %0d", what, want, got, cycles);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned active_limit();
      return (tracked_cfg > MAX_BLOCKS) ? MAX_BLOCKS : tracked_cfg;
   endfunction

   task automatic compute_answer(input req_kind_type kind, input logic [RUN_W-1:0] run,
                                 input logic [BLK_W-1:0] blk, input logic [WIDX_W-1:0] widx,
                                 output allocator_answer_type ans);
      int unsigned limit;
      int unsigned len;
      int unsigned b;
      bit          found;
      bit          fits;
      limit = active_limit();
      ans.run_start   = '0;
      ans.status      = ST_OK;
      ans.bitmap_word = '0;
      case (kind)
         REQ_ALLOC: begin
            len   = (run > MAX_RUN) ? MAX_RUN : run;
            found = 1'b0;
            while (!found && seek_ptr < limit) begin
               if (used_blk[seek_ptr]) begin
                  seek_ptr++;
               end else begin
                  fits = 1'b1;
                  // A collision restarts the search on the blocking block.
                  for (int unsigned i = 1; i < len && fits; i++) begin
                     b = seek_ptr + i;
                     if (b >= limit) begin
                        seek_ptr = limit;
                        fits     = 1'b0;
                     end else if (used_blk[b]) begin
                        seek_ptr = b;
                        fits     = 1'b0;
                     end
                  end
                  found = fits;
               end
            end
            if (found) begin
               ans.run_start = BLK_W'(seek_ptr);
               for (int unsigned i = 0; i < len; i++) used_blk[seek_ptr + i] = 1'b1;
               seek_ptr += len;
            end else begin
               ans.status = ST_EXHAUSTED;
            end
         end
         REQ_MARK: begin
            if (blk < limit) used_blk[blk] = 1'b1;
            else ans.status = ST_OUT_OF_RANGE;
         end
         REQ_READ: begin
            for (int i = 0; i < WORD_BITS; i++)
               ans.bitmap_word[i] = used_blk[int'(widx) * WORD_BITS + i];
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input req_kind_type kind, input logic [RUN_W-1:0] run,
                               input logic [BLK_W-1:0] blk, input logic [WIDX_W-1:0] widx);
      int gap;
      allocator_answer_type ans;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {widx, blk, run};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      compute_answer(kind, run, blk, widx, ans);
      answer_queue.push_back(ans);
   endtask

   // Stops the request stream and waits until every answer is back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tracked(input int unsigned value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= PTR_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      tracked_cfg  = value & 32'h7FFF;
      repeat (2) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_request(REQ_READ, '0, '0, '0);
      send_request(REQ_READ, '1, '1, '1);
      send_request(REQ_NONE, '1, '1, '1);
      settle();
   endtask

   task automatic test_alloc_basics();
      send_request(REQ_ALLOC, 9'd0, '1, '1);
      send_request(REQ_ALLOC, 9'd1, '0, '0);
      send_request(REQ_MARK, 9'd0, 14'd5, '0);
      // Block 5 sits inside the run, so the search has to retry past it.
      send_request(REQ_ALLOC, 9'd8, '0, '0);
      send_request(REQ_ALLOC, 9'd511, '0, '0);
      send_request(REQ_ALLOC, 9'd256, '0, '0);
      send_request(REQ_READ, '0, '0, 9'd0);
      send_request(REQ_READ, '0, '0, 9'd8);
      settle();
   endtask

   task automatic test_mark_and_read();
      send_request(REQ_MARK, '0, 14'd16383, '0);
      send_request(REQ_READ, '0, '0, 9'd511);
      send_request(REQ_MARK, '0, 14'd0, '0);
      send_request(REQ_READ, '0, '0, 9'd0);
      settle();
   endtask

   task automatic test_limits();
      write_tracked(300);
      send_request(REQ_ALLOC, 9'd4, '0, '0);
      send_request(REQ_MARK, '0, 14'd299, '0);
      send_request(REQ_MARK, '0, 14'd300, '0);
      write_tracked(0);
      send_request(REQ_ALLOC, 9'd1, '0, '0);
      send_request(REQ_MARK, '0, 14'd0, '0);
      write_tracked(32767);
      send_request(REQ_MARK, '0, 14'd16383, '0);
      write_tracked(1);
      send_request(REQ_ALLOC, 9'd0, '0, '0);
      // A run that crosses the limit parks the pointer on the limit.
      write_tracked(seek_ptr + 50);
      send_request(REQ_ALLOC, 9'd100, '0, '0);
      send_request(REQ_ALLOC, 9'd0, '0, '0);
      write_tracked(MAX_BLOCKS);
   endtask

   task automatic test_random_traffic(input int count);
      int          r;
      int          pick;
      int unsigned near;
      logic [RUN_W-1:0]  run;
      logic [BLK_W-1:0]  blk;
      logic [WIDX_W-1:0] widx;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r    = $urandom_range(0, 99);
         run  = RUN_W'($urandom_range(0, 511));
         blk  = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
         widx = WIDX_W'($urandom_range(0, MAP_WORDS - 1));
         if (r < 45) begin
            // Mostly short runs, so the pointer lasts through the whole run.
            pick = $urandom_range(0, 99);
            if (pick < 75) run = RUN_W'($urandom_range(0, 4));
            else if (pick < 97) run = RUN_W'($urandom_range(5, 24));
            else run = RUN_W'($urandom_range(200, 511));
            send_request(REQ_ALLOC, run, blk, widx);
         end else if (r < 70) begin
            pick = $urandom_range(0, 99);
            near = seek_ptr + $urandom_range(1, 40);
            if (pick < 60 && near < MAX_BLOCKS) blk = BLK_W'(near);
            else if (pick < 70 && active_limit() < MAX_BLOCKS)
               blk = BLK_W'($urandom_range(active_limit(), MAX_BLOCKS - 1));
            send_request(REQ_MARK, run, blk, widx);
         end else if (r < 95) begin
            if ($urandom_range(0, 99) < 60) begin
               near = seek_ptr / WORD_BITS;
               near = (near > 2) ? near - $urandom_range(0, 2) : near;
               widx = WIDX_W'((near > MAP_WORDS - 1) ? MAP_WORDS - 1 : near);
            end
            send_request(REQ_READ, run, blk, widx);
         end else begin
            send_request(REQ_NONE, run, blk, widx);
         end
      end
      no_idle = 1'b0;
      settle();
   endtask

   // Result side: random back-pressure.
   always @(posedge clock) begin
      static int hold_left = 0;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 12) begin
         hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      allocator_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_queue.size() == 0) begin
            report_mismatch("unexpected beat", 0, rsp_tdata);
         end else begin
            want = answer_queue.pop_front();
            if (rsp_tdata[13:0] !== want.run_start)
               report_mismatch("run_start", want.run_start, rsp_tdata[13:0]);
            if (rsp_tuser !== want.status)
               report_mismatch("status", want.status, rsp_tuser);
            if (rsp_tdata[45:14] !== want.bitmap_word)
               report_mismatch("bitmap_word", want.bitmap_word, rsp_tdata[45:14]);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned lo;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_alloc_basics();
      test_mark_and_read();
      test_limits();
      write_tracked(32767);
      test_random_traffic(475);
      lo = (seek_ptr + 1500 > MAX_BLOCKS) ? MAX_BLOCKS : seek_ptr + 1500;
      write_tracked($urandom_range(lo, MAX_BLOCKS));
      test_random_traffic(475);
      write_tracked(MAX_BLOCKS);
      test_random_traffic(475);
      // Tight limit so that the pointer runs into it during the last phase.
      lo = seek_ptr + $urandom_range(200, 1500);
      write_tracked((lo > MAX_BLOCKS) ? MAX_BLOCKS : lo);
      test_random_traffic(475);
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
